@@ hw/rtl/indexed_list_engine_macros.svh @@
// assertion macros shared by the indexed list engine modules
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ILE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ile assertion failed");
// condition must never be seen outside reset
`define ILE_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ile forbidden condition seen");
`else
`define ILE_ASSERT(lbl, clk, rst_n, prop)
`define ILE_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/ile_pkg.sv @@
// types and codes shared by the indexed list engine modules
`timescale 1ns / 1ps

package ile_pkg;

    // request codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_GET    = 3'd2,
        MODE_LOCATE = 3'd3,
        MODE_PRED   = 3'd4,
        MODE_SUCC   = 3'd5,
        MODE_CLEAR  = 3'd6
    } t_mode;

    // how the result registers are updated
    typedef enum logic [2:0] {
        RES_NONE,
        RES_ERR,
        RES_OK,
        RES_RD,
        RES_HIT
    } t_res_op;

    // input transaction
    typedef struct packed {
        logic [2:0]         mode;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_req;

    // output transaction
    typedef struct packed {
        logic               status;
        logic signed [31:0] data;
        logic [5:0]         found_position;
        logic [6:0]         count;
        logic               empty_res;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic    load_req;
        logic    ins_init;
        logic    ins_step;
        logic    ins_write;
        logic    rd_pos;
        logic    del_init;
        logic    del_step;
        logic    del_commit;
        logic    scan_init;
        logic    scan_step;
        logic    clear;
        t_res_op res_op;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] mode;
        logic       ins_ok;
        logic       idx_ok;
        logic       idx_above_pos;
        logic       idx_below_count;
        logic       mv_pending;
        logic       sc_pending;
        logic       hit;
    } t_dp_sts;

endpackage

@@ hw/rtl/ile_datapath.sv @@
// list storage, shift and scan datapath of the indexed list engine
`timescale 1ns / 1ps
`include "indexed_list_engine_macros.svh"

module ile_datapath #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ile_pkg::t_req    i_req,
    input  ile_pkg::t_dp_cmd i_cmd,
    output ile_pkg::t_dp_sts o_sts,
    output ile_pkg::t_rsp    o_rsp
);
    import ile_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    // storage
    logic [ELEM_WIDTH-1:0] mem [CAPACITY];

    // request and control registers
    t_req                  r_req;
    logic [ELEM_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_mv_valid;
    logic [AW-1:0]         r_mv_dest;
    logic                  r_sc_valid;
    logic [CW-1:0]         r_sc_idx;
    logic [ELEM_WIDTH-1:0] r_rd_data;
    logic [ELEM_WIDTH-1:0] r_prev;
    logic                  r_res_status;
    logic [31:0]           r_res_data;
    logic [5:0]            r_res_fpos;
    t_rsp                  r_rsp;

    logic [ELEM_WIDTH-1:0] in_elem;
    logic [31:0]           cur_data;
    logic [31:0]           prev_data;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         pos_inc;
    logic [XW-1:0]         count_x;
    logic [XW-1:0]         idx_x;
    logic [XW-1:0]         sc_idx_x;
    logic [CW-1:0]         idx_dec;
    logic [CW-1:0]         idx_inc;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic                  cur_eq;
    logic                  prev_eq;
    logic                  sc_nz;
    logic                  hit;
    logic [31:0]           hit_data;

    // input value to element width, element to 32-bit result data
    if (ELEM_WIDTH <= 32) begin : g_in_narrow
        assign in_elem = i_req.value[ELEM_WIDTH-1:0];
    end else begin : g_in_wide
        assign in_elem = {{(ELEM_WIDTH - 32){i_req.value[31]}}, i_req.value};
    end

    if (ELEM_WIDTH >= 32) begin : g_out_wide
        assign cur_data  = r_rd_data[31:0];
        assign prev_data = r_prev[31:0];
    end else begin : g_out_narrow
        assign cur_data  = {{(32 - ELEM_WIDTH){r_rd_data[ELEM_WIDTH-1]}}, r_rd_data};
        assign prev_data = {{(32 - ELEM_WIDTH){r_prev[ELEM_WIDTH-1]}}, r_prev};
    end

    // index arithmetic
    assign pos_x    = XW'(r_req.position);
    assign pos_inc  = pos_x + XW'(1);
    assign count_x  = XW'(r_count);
    assign idx_x    = XW'(r_idx);
    assign sc_idx_x = XW'(r_sc_idx);
    assign idx_dec  = r_idx - CW'(1);
    assign idx_inc  = r_idx + CW'(1);

    // read address select
    always_comb begin
        if (i_cmd.ins_step) begin
            rd_addr = idx_dec[AW-1:0];
        end else if (i_cmd.rd_pos) begin
            rd_addr = pos_x[AW-1:0];
        end else begin
            rd_addr = r_idx[AW-1:0];
        end
    end

    // pending move has the write port, otherwise the new element
    assign wr_en   = r_mv_valid | i_cmd.ins_write;
    assign wr_addr = r_mv_valid ? r_mv_dest : pos_x[AW-1:0];
    assign wr_data = r_mv_valid ? r_rd_data : r_val;

    // scan compare on the registered read data
    assign cur_eq   = (r_rd_data == r_val);
    assign prev_eq  = (r_prev == r_val);
    assign sc_nz    = (r_sc_idx != '0);
    assign hit_data = (r_req.mode == MODE_PRED) ? prev_data : cur_data;

    always_comb begin
        unique case (r_req.mode)
            MODE_LOCATE: hit = r_sc_valid & cur_eq;
            MODE_PRED:   hit = r_sc_valid & sc_nz & cur_eq;
            MODE_SUCC:   hit = r_sc_valid & sc_nz & prev_eq;
            default:     hit = 1'b0;
        endcase
    end

    // status to controller
    always_comb begin
        o_sts                 = '0;
        o_sts.mode            = r_req.mode;
        o_sts.ins_ok          = (count_x < CAP_X) && (pos_x <= count_x);
        o_sts.idx_ok          = (pos_x < count_x);
        o_sts.idx_above_pos   = (idx_x > pos_x);
        o_sts.idx_below_count = (idx_x < count_x);
        o_sts.mv_pending      = r_mv_valid;
        o_sts.sc_pending      = r_sc_valid;
        o_sts.hit             = hit;
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_mv_valid <= 1'b0;
            r_sc_valid <= 1'b0;
        end else begin
            r_mv_valid <= i_cmd.ins_step | i_cmd.del_step;
            r_sc_valid <= i_cmd.scan_step;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.ins_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.del_commit) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // request, index and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
            r_val <= in_elem;
        end

        if (i_cmd.ins_init) begin
            r_idx <= r_count;
        end else if (i_cmd.ins_step) begin
            r_idx <= idx_dec;
        end else if (i_cmd.del_init) begin
            r_idx <= CW'(pos_inc);
        end else if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.del_step || i_cmd.scan_step) begin
            r_idx <= idx_inc;
        end

        if (i_cmd.ins_step) begin
            r_mv_dest <= r_idx[AW-1:0];
        end else if (i_cmd.del_step) begin
            r_mv_dest <= idx_dec[AW-1:0];
        end

        if (i_cmd.scan_step) begin
            r_sc_idx <= r_idx;
        end
        if (r_sc_valid) begin
            r_prev <= r_rd_data;
        end

        unique case (i_cmd.res_op)
            RES_ERR: begin
                r_res_status <= 1'b1;
                r_res_data   <= '0;
                r_res_fpos   <= '0;
            end
            RES_OK: begin
                r_res_status <= 1'b0;
                r_res_data   <= '0;
                r_res_fpos   <= '0;
            end
            RES_RD: begin
                r_res_status <= 1'b0;
                r_res_data   <= cur_data;
                r_res_fpos   <= '0;
            end
            RES_HIT: begin
                r_res_status <= 1'b0;
                if (r_req.mode == MODE_LOCATE) begin
                    r_res_data <= '0;
                    r_res_fpos <= sc_idx_x[5:0];
                end else begin
                    r_res_data <= hit_data;
                    r_res_fpos <= '0;
                end
            end
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            r_rsp.status         <= r_res_status;
            r_rsp.data           <= r_res_data;
            r_rsp.found_position <= r_res_fpos;
            r_rsp.count          <= count_x[6:0];
            r_rsp.empty_res      <= (r_count == '0);
        end
    end

    assign o_rsp = r_rsp;

    // checks
    `ILE_NEVER(a_count_cap, i_clk, i_rst_n, r_count > CW'(CAPACITY))
    `ILE_NEVER(a_write_clash, i_clk, i_rst_n, r_mv_valid && i_cmd.ins_write)
    `ILE_ASSERT(a_count_step, i_clk, i_rst_n, !i_cmd.clear |=> (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)))

endmodule

@@ hw/rtl/ile_controller.sv @@
// sequencing state machine of the indexed list engine
`timescale 1ns / 1ps
`include "indexed_list_engine_macros.svh"

module ile_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ile_pkg::t_dp_sts i_sts,
    output ile_pkg::t_dp_cmd o_cmd
);
    import ile_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_RD_CAP,
        S_DEL_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    // next state and per-cycle datapath commands
    always_comb begin
        cmd        = '0;
        cmd.res_op = RES_NONE;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode)
                    MODE_INSERT: begin
                        if (i_sts.ins_ok) begin
                            cmd.ins_init = 1'b1;
                            n_state      = S_INS_SHIFT;
                        end else begin
                            cmd.res_op = RES_ERR;
                            n_state    = S_DONE;
                        end
                    end
                    MODE_DELETE, MODE_GET: begin
                        if (i_sts.idx_ok) begin
                            cmd.rd_pos = 1'b1;
                            n_state    = S_RD_CAP;
                        end else begin
                            cmd.res_op = RES_ERR;
                            n_state    = S_DONE;
                        end
                    end
                    MODE_LOCATE, MODE_PRED, MODE_SUCC: begin
                        cmd.scan_init = 1'b1;
                        n_state       = S_SCAN;
                    end
                    MODE_CLEAR: begin
                        cmd.clear  = 1'b1;
                        cmd.res_op = RES_OK;
                        n_state    = S_DONE;
                    end
                    default: begin
                        cmd.res_op = RES_ERR;
                        n_state    = S_DONE;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                // move entries up from the tail, then drop in the new one
                if (i_sts.idx_above_pos) begin
                    cmd.ins_step = 1'b1;
                end else if (!i_sts.mv_pending) begin
                    cmd.ins_write = 1'b1;
                    cmd.res_op    = RES_OK;
                    n_state       = S_DONE;
                end
            end
            S_RD_CAP: begin
                cmd.res_op = RES_RD;
                if (i_sts.mode == MODE_DELETE) begin
                    cmd.del_init = 1'b1;
                    n_state      = S_DEL_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DEL_SHIFT: begin
                // move entries down over the removed one
                if (i_sts.idx_below_count) begin
                    cmd.del_step = 1'b1;
                end else if (!i_sts.mv_pending) begin
                    cmd.del_commit = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    cmd.res_op = RES_HIT;
                    n_state    = S_DONE;
                end else if (i_sts.idx_below_count) begin
                    cmd.scan_step = 1'b1;
                end else if (!i_sts.sc_pending) begin
                    cmd.res_op = RES_ERR;
                    n_state    = S_DONE;
                end else begin
                    // last compare still in flight
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output transaction pending flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // checks
    `ILE_NEVER(a_no_overwrite, i_clk, i_rst_n, cmd.out_load && r_out_valid && !i_out_ready)
    `ILE_ASSERT(a_one_item, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)

endmodule

@@ hw/rtl/indexed_list_engine.sv @@
// top level of the indexed list engine
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed elements held in a two-port memory
// (one write and one registered read per cycle). One request is worked at a
// time; a finished result sits in the output register, so the next request is
// taken while it waits. Bad positions and unused modes return an error;
// insert and delete shift every entry behind the position, each shifted entry
// passing once through the memory port; locate, predecessor and successor
// scan from the head of the list until a match or its end. Clear only
// empties the list; entries are not swept.
module indexed_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ile_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ile_pkg::t_rsp o_out_data
);
    import ile_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    ile_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // storage and compare
    ile_datapath #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out_data)
    );

endmodule

@@ tb/tb_indexed_list_engine.sv @@
// self-checking testbench for the indexed list engine
`timescale 1ns / 1ps

module tb_indexed_list_engine;
    import ile_pkg::*;

    // shadow copy of the list: predicts each result and checks the returned transactions
    class ordered_list_tracker;
        int                 cap;
        logic signed [31:0] shadow_entries [];
        int                 fill;
        int                 peak_fill;
        int                 requests_seen;
        int                 results_checked;
        int                 rejects_seen;
        int                 errors;
        t_rsp               pending_rsp [$];

        function new(int cap_i);
            cap = cap_i;
            shadow_entries = new[cap_i];
            fill = 0;
            peak_fill = 0;
            requests_seen = 0;
            results_checked = 0;
            rejects_seen = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        function logic signed [31:0] entry_at(int idx);
            return shadow_entries[idx];
        endfunction

        // apply one accepted request to the shadow list and queue its result
        function void note_request(t_req req);
            t_rsp               want;
            int                 i;
            int                 pos;
            logic signed [31:0] v;
            want = '0;
            want.status = 1'b1;
            pos = int'(req.position);
            v = req.value;
            case (req.mode)
                MODE_INSERT: begin
                    if (fill < cap && pos <= fill) begin
                        for (i = fill; i > pos; i--)
                            shadow_entries[i] = shadow_entries[i - 1];
                        shadow_entries[pos] = v;
                        fill++;
                        want.status = 1'b0;
                    end
                end
                MODE_DELETE: begin
                    if (pos < fill) begin
                        want.data = shadow_entries[pos];
                        for (i = pos; i + 1 < fill; i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        fill--;
                        want.status = 1'b0;
                    end
                end
                MODE_GET: begin
                    if (pos < fill) begin
                        want.data = shadow_entries[pos];
                        want.status = 1'b0;
                    end
                end
                MODE_LOCATE: begin
                    for (i = 0; i < fill; i++) begin
                        if (want.status && shadow_entries[i] == v) begin
                            want.found_position = i[5:0];
                            want.status = 1'b0;
                        end
                    end
                end
                MODE_PRED: begin
                    // the head entry has no predecessor, so matching starts at 1
                    for (i = 1; i < fill; i++) begin
                        if (want.status && shadow_entries[i] == v) begin
                            want.data = shadow_entries[i - 1];
                            want.status = 1'b0;
                        end
                    end
                end
                MODE_SUCC: begin
                    // the tail entry has no successor
                    for (i = 0; i + 1 < fill; i++) begin
                        if (want.status && shadow_entries[i] == v) begin
                            want.data = shadow_entries[i + 1];
                            want.status = 1'b0;
                        end
                    end
                end
                MODE_CLEAR: begin
                    for (i = 0; i < cap; i++)
                        shadow_entries[i] = '0;
                    fill = 0;
                    want.status = 1'b0;
                end
                default: ;
            endcase
            want.count = fill[6:0];
            want.empty_res = (fill == 0);
            if (want.status)
                rejects_seen++;
            if (fill > peak_fill)
                peak_fill = fill;
            requests_seen++;
            pending_rsp.push_back(want);
        endfunction

        // compare one returned transaction with the oldest prediction
        function void check_response(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: result with nothing pending: status %0b data %0d count %0d",
                         $time, got.status, got.data, got.count);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            results_checked++;
            if (got.status !== want.status) begin
                $display("%0t: status expected %0b got %0b", $time, want.status, got.status);
                errors++;
            end
            if (got.data !== want.data) begin
                $display("%0t: data expected %0d (%h) got %0d (%h)",
                         $time, want.data, want.data, got.data, got.data);
                errors++;
            end
            if (got.found_position !== want.found_position) begin
                $display("%0t: found_position expected %0d got %0d",
                         $time, want.found_position, got.found_position);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
                errors++;
            end
            if (got.empty_res !== want.empty_res) begin
                $display("%0t: empty_res expected %0b got %0b",
                         $time, want.empty_res, got.empty_res);
                errors++;
            end
        endfunction
    endclass

    localparam int                 CAPACITY     = 64;
    localparam int                 RANDOM_ITEMS = 900;
    localparam int                 DRAIN_CYCLES = 80;
    localparam logic [2:0]         MODE_UNUSED  = 3'd7;
    localparam logic signed [31:0] VAL_MAX      = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN      = 32'sh80000000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    ordered_list_tracker tracker;
    bit                  in_quiet  = 1'b0;
    bit                  out_quiet = 1'b0;
    int                  out_stall = 0;

    indexed_list_engine #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (32)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // values biased toward extremes and repeats so searches find duplicates
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sd0;
            1:       return 32'sd1;
            2:       return -32'sd1;
            3:       return VAL_MIN;
            4:       return VAL_MAX;
            5:       return 32'sh55555555;
            6:       return 32'shaaaaaaaa;
            7:       return 32'sd7;
            default: return $urandom;
        endcase
    endfunction

    // search key: usually something already in the list
    function automatic logic signed [31:0] pick_key();
        if (tracker.fill > 0 && $urandom_range(0, 9) < 7)
            return tracker.entry_at($urandom_range(0, tracker.fill - 1));
        return pick_value();
    endfunction

    // offer one transaction after a random gap and wait for it to be taken
    task automatic send_request(logic [2:0] mode, logic [6:0] pos, logic signed [31:0] val);
        t_req req;
        int   gap;
        req.mode = mode;
        req.position = pos;
        req.value = val;
        if ($urandom_range(0, 99) < 3)
            in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tracker.note_request(req);
    endtask

    // result side: take a transaction, then hold ready low for a random stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                tracker.check_response(o_out_data);
                if ($urandom_range(0, 99) < 3)
                    out_quiet = !out_quiet;
                out_stall = out_quiet ? 0 : $urandom_range(0, 8);
            end else if (out_stall > 0) begin
                out_stall--;
            end
            i_out_ready <= (out_stall == 0);
        end
    end

    initial begin
        int         n;
        int         roll;
        bit         growing;
        logic [2:0] mode;
        logic [6:0] pos;

        tracker = new(CAPACITY);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, bad positions, extremes, edge neighbours
        send_request(MODE_GET,    7'd0,   32'sd0);
        send_request(MODE_DELETE, 7'd0,   32'sd0);
        send_request(MODE_LOCATE, 7'd0,   32'sd0);
        send_request(MODE_INSERT, 7'd1,   32'sd5);
        send_request(MODE_INSERT, 7'd0,   VAL_MAX);
        send_request(MODE_INSERT, 7'd0,   VAL_MIN);
        send_request(MODE_INSERT, 7'd2,   32'sd0);
        send_request(MODE_INSERT, 7'd1,   -32'sd1);
        send_request(MODE_INSERT, 7'd64,  32'sd9);
        send_request(MODE_INSERT, 7'd127, 32'sd9);
        send_request(MODE_GET,    7'd3,   32'sd0);
        send_request(MODE_LOCATE, 7'd0,   VAL_MAX);
        send_request(MODE_PRED,   7'd0,   VAL_MIN);
        send_request(MODE_SUCC,   7'd0,   32'sd0);
        send_request(MODE_PRED,   7'd0,   -32'sd1);
        send_request(MODE_SUCC,   7'd0,   -32'sd1);
        send_request(MODE_LOCATE, 7'd0,   32'sd12345);
        send_request(MODE_UNUSED, 7'd0,   32'sd0);
        send_request(MODE_DELETE, 7'd1,   32'sd0);
        send_request(MODE_DELETE, 7'd0,   32'sd0);
        send_request(MODE_INSERT, 7'd2,   VAL_MAX);
        send_request(MODE_PRED,   7'd0,   VAL_MAX);
        send_request(MODE_SUCC,   7'd0,   VAL_MAX);
        send_request(MODE_CLEAR,  7'd0,   32'sd0);
        send_request(MODE_GET,    7'd0,   32'sd0);

        // random: alternate growing to full and draining to empty
        growing = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            n = tracker.fill;
            roll = $urandom_range(0, 199);
            if (roll < 1)
                mode = MODE_CLEAR;
            else if (roll < 3)
                mode = MODE_UNUSED;
            else if (roll < (growing ? 103 : 33))
                mode = MODE_INSERT;
            else if (roll < (growing ? 123 : 113))
                mode = MODE_DELETE;
            else if (roll < 143)
                mode = MODE_GET;
            else if (roll < 163)
                mode = MODE_LOCATE;
            else if (roll < 181)
                mode = MODE_PRED;
            else
                mode = MODE_SUCC;

            // mostly legal positions, sometimes anything the field holds
            if ($urandom_range(0, 99) < 12)
                pos = 7'($urandom_range(0, 127));
            else if (mode == MODE_INSERT)
                pos = 7'($urandom_range(0, n));
            else
                pos = (n > 0) ? 7'($urandom_range(0, n - 1)) : 7'd0;

            if (mode == MODE_INSERT || mode == MODE_CLEAR || mode == MODE_UNUSED)
                send_request(mode, pos, pick_value());
            else
                send_request(mode, pos, pick_key());

            // turn around once an insert has hit a full list or a delete an empty one
            if (growing && mode == MODE_INSERT && n == CAPACITY)
                growing = 1'b0;
            else if (!growing && mode == MODE_DELETE && n == 0)
                growing = 1'b1;
        end
        i_in_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (tracker.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests %0d, results checked %0d, rejected requests %0d",
                 tracker.requests_seen, tracker.results_checked, tracker.rejects_seen);
        $display("deepest list %0d of %0d entries, mismatches %0d",
                 tracker.peak_fill, CAPACITY, tracker.errors);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
